// ===== hw/rtl/ihv_pkg.sv =====
// ----------------------------------------------------------------------------
// ihv_pkg
// Types and constants shared by the IPv4 header validator and its checker.
// ----------------------------------------------------------------------------
package ihv_pkg;

	localparam logic [15:0] COUNT_LIMIT      = 16'hffff;
	localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
	localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
	localparam logic [3:0]  IP_VERSION_FOUR  = 4'd4;

	localparam logic [15:0] OFS_VER_IHL  = 16'd0;
	localparam logic [15:0] OFS_TLEN_HI  = 16'd2;
	localparam logic [15:0] OFS_TLEN_LO  = 16'd3;
	localparam logic [15:0] OFS_CSUM_HI  = 16'd10;
	localparam logic [15:0] OFS_CSUM_LO  = 16'd11;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_BAD_VERSION = 3'd2,
		ST_HDR_SMALL   = 3'd3,
		ST_TRUNCATED   = 3'd4,
		ST_CSUM_BAD    = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] computed_checksum;
		logic [15:0] received_length;
	} result_item_t;

endpackage

// ===== hw/rtl/ipv4_header_validator.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_validator
// Checks one IPv4 packet fed a byte per transaction, in network order, with
// a mark on its final byte. One byte is taken every cycle unless a final byte
// stalls in the input register, where the field capture and the ones'-
// complement add are done; the final byte's status then lands in the result
// register. Bytes keep flowing while a result waits, until a further final
// byte meets a result not yet taken.
// ----------------------------------------------------------------------------
module ipv4_header_validator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_ready,
	input  ihv_pkg::byte_item_t      byte_item,
	output logic                     result_valid,
	input  logic                     result_ready,
	output ihv_pkg::result_item_t    result_item
);

	logic                  valid_s1;
	ihv_pkg::byte_item_t   item_s1;
	logic                  adv_s1;

	logic [15:0] byte_count_q, cnt_nxt;
	logic [3:0]  version_q, version_nxt;
	logic [3:0]  hwords_q, hwords_nxt;
	logic [15:0] claimed_q, claimed_nxt;
	logic [15:0] stored_q, stored_nxt;
	logic [15:0] sum_q, sum_nxt;
	logic [7:0]  held_q, held_nxt;

	logic [5:0]  hdr_bytes;
	logic [7:0]  add_byte;
	logic [16:0] raw_sum;
	logic [15:0] calc;
	ihv_pkg::status_t status;
	logic        res_valid_q;
	ihv_pkg::result_item_t res_q;

	assign adv_s1     = valid_s1 && (!item_s1.last_byte || !res_valid_q || result_ready);
	assign byte_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	always_comb begin
		cnt_nxt     = (byte_count_q != ihv_pkg::COUNT_LIMIT) ? byte_count_q + 16'd1
		                                                    : byte_count_q;
		version_nxt = version_q;
		hwords_nxt  = hwords_q;
		claimed_nxt = claimed_q;
		stored_nxt  = stored_q;
		held_nxt    = held_q;
		sum_nxt     = sum_q;
		unique case (byte_count_q)
			ihv_pkg::OFS_VER_IHL: begin
				version_nxt = item_s1.data_byte[7:4];
				hwords_nxt  = item_s1.data_byte[3:0];
			end
			ihv_pkg::OFS_TLEN_HI: claimed_nxt[15:8] = item_s1.data_byte;
			ihv_pkg::OFS_TLEN_LO: claimed_nxt[7:0]  = item_s1.data_byte;
			ihv_pkg::OFS_CSUM_HI: stored_nxt[15:8]  = item_s1.data_byte;
			ihv_pkg::OFS_CSUM_LO: stored_nxt[7:0]   = item_s1.data_byte;
			default: ;
		endcase
		hdr_bytes = {hwords_nxt, 2'b00};
		add_byte  = (byte_count_q == ihv_pkg::OFS_CSUM_HI ||
		             byte_count_q == ihv_pkg::OFS_CSUM_LO) ? 8'h00 : item_s1.data_byte;
		raw_sum   = {1'b0, sum_q} + {1'b0, held_q, add_byte};
		if (byte_count_q < {10'd0, hdr_bytes}) begin
			if (!byte_count_q[0]) begin
				held_nxt = add_byte;
			end else begin
				sum_nxt = raw_sum[15:0] + {15'd0, raw_sum[16]};
			end
		end
		calc = ~sum_nxt;
		priority if (cnt_nxt < ihv_pkg::MIN_HEADER_BYTES) begin
			status = ihv_pkg::ST_TOO_SHORT;
		end else if (version_nxt != ihv_pkg::IP_VERSION_FOUR) begin
			status = ihv_pkg::ST_BAD_VERSION;
		end else if (hwords_nxt < ihv_pkg::MIN_HEADER_WORDS) begin
			status = ihv_pkg::ST_HDR_SMALL;
		end else if (claimed_nxt > cnt_nxt || cnt_nxt < {10'd0, hdr_bytes}) begin
			status = ihv_pkg::ST_TRUNCATED;
		end else if (stored_nxt != calc) begin
			status = ihv_pkg::ST_CSUM_BAD;
		end else begin
			status = ihv_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			version_q    <= '0;
			hwords_q     <= '0;
			claimed_q    <= '0;
			stored_q     <= '0;
			sum_q        <= '0;
			held_q       <= '0;
		end else if (adv_s1) begin
			if (item_s1.last_byte) begin
				byte_count_q <= '0;
				version_q    <= '0;
				hwords_q     <= '0;
				claimed_q    <= '0;
				stored_q     <= '0;
				sum_q        <= '0;
				held_q       <= '0;
			end else begin
				byte_count_q <= cnt_nxt;
				version_q    <= version_nxt;
				hwords_q     <= hwords_nxt;
				claimed_q    <= claimed_nxt;
				stored_q     <= stored_nxt;
				sum_q        <= sum_nxt;
				held_q       <= held_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last_byte) begin
			res_q.status            <= status;
			res_q.computed_checksum <= calc;
			res_q.received_length   <= cnt_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_q;

endmodule

// ===== hw/rtl/ihv_checker.sv =====
// ----------------------------------------------------------------------------
// ihv_checker
// Port-level checks on the IPv4 header validator, bound into the validator module.
// ----------------------------------------------------------------------------
module ihv_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_valid,
	input logic                  byte_ready,
	input ihv_pkg::byte_item_t   byte_item,
	input logic                  result_valid,
	input logic                  result_ready,
	input ihv_pkg::result_item_t result_item
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("result transaction dropped or changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_item.status <= ihv_pkg::ST_CSUM_BAD &&
		                 result_item.received_length != 16'd0)
		else $error("result with undefined status or empty packet");

	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result_item.status == ihv_pkg::ST_TOO_SHORT) ==
		                 (result_item.received_length < ihv_pkg::MIN_HEADER_BYTES)))
		else $error("too-short status disagrees with received length");

	a_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && byte_ready && byte_item.last_byte, 2) ||
		                        $past(!byte_ready, 1))
		else $error("result without a final byte taken");

endmodule

bind ipv4_header_validator ihv_checker u_ihv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_ready   (byte_ready),
	.byte_item    (byte_item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_item  (result_item)
);
